// File: rtl/core/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

  localparam int unsigned POS_W    = 12;
  localparam int unsigned PIX_W    = 12;
  localparam int unsigned CTR_W    = 11;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned REST_W   = 24;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_REST_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_MAX   = 3'd7;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  localparam logic [MODE_W-1:0] MODE_TRACK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROAM  = 2'd2;

  localparam logic signed [POS_W-1:0] AIM_HOME = 12'sd90;

  localparam logic [REST_W-1:0]       RST_REST_TICKS = 24'd5000;
  localparam logic [CTR_W-1:0]        RST_CENTER_X   = 11'd320;
  localparam logic [CTR_W-1:0]        RST_CENTER_Y   = 11'd240;
  localparam logic [STEP_W-1:0]       RST_SWEEP_STEP = 8'd1;
  localparam logic signed [POS_W-1:0] RST_PAN_MIN    = 12'sd0;
  localparam logic signed [POS_W-1:0] RST_PAN_MAX    = 12'sd180;
  localparam logic signed [POS_W-1:0] RST_TILT_MIN   = 12'sd75;
  localparam logic signed [POS_W-1:0] RST_TILT_MAX   = 12'sd125;

  typedef struct packed {
    logic             action;
    logic             face_found;
    logic [PIX_W-1:0] face_x;
    logic [PIX_W-1:0] face_y;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pan_out;
    logic signed [POS_W-1:0] tilt_out;
    logic [MODE_W-1:0]       mode_out;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/pan_tilt_track_roam_fsm_core.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | in_item_t: action, face_found, face_x, face_y
// out_    | output    | out_valid/out_stall | out_item_t: pan_out, tilt_out, mode_out
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index (register), cfg_data
//
// One item per cycle while in_stall is low; a frame result is registered for out_.
// Ticks update the sleep timer only and give no result.
// A two-entry output buffer (result register plus skid) lets an item enter while a
// result waits; in_stall rises only when both entries are full.
// Synchronous reset restores aim 90/90, registers to defaults; cfg_ready is always high.
`default_nettype none

module pan_tilt_track_roam_fsm_core
  import ptt_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned CMP_W = (TIMER_BITS > REST_W) ? TIMER_BITS : REST_W;
  localparam logic [TIMER_BITS-1:0] TIMER_FULL = {TIMER_BITS{1'b1}};
  localparam int unsigned SUM_W = POS_W + 2;

  function automatic logic signed [POS_W-1:0] sat12(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2047);
    lo = -SUM_W'(2048);
    if (v > hi) begin
      return 12'sh7ff;
    end else if (v < lo) begin
      return 12'sh800;
    end
    return v[POS_W-1:0];
  endfunction

  // configuration
  logic [REST_W-1:0]       rest_ticks_r;
  logic [CTR_W-1:0]        center_x_r;
  logic [CTR_W-1:0]        center_y_r;
  logic [STEP_W-1:0]       sweep_step_r;
  logic signed [POS_W-1:0] pan_min_r;
  logic signed [POS_W-1:0] pan_max_r;
  logic signed [POS_W-1:0] tilt_min_r;
  logic signed [POS_W-1:0] tilt_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_ticks_r <= RST_REST_TICKS;
      center_x_r   <= RST_CENTER_X;
      center_y_r   <= RST_CENTER_Y;
      sweep_step_r <= RST_SWEEP_STEP;
      pan_min_r    <= RST_PAN_MIN;
      pan_max_r    <= RST_PAN_MAX;
      tilt_min_r   <= RST_TILT_MIN;
      tilt_max_r   <= RST_TILT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REST_TICKS: rest_ticks_r <= cfg_data[REST_W-1:0];
        REG_CENTER_X:   center_x_r   <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:   center_y_r   <= cfg_data[CTR_W-1:0];
        REG_SWEEP_STEP: sweep_step_r <= cfg_data[STEP_W-1:0];
        REG_PAN_MIN:    pan_min_r    <= cfg_data[POS_W-1:0];
        REG_PAN_MAX:    pan_max_r    <= cfg_data[POS_W-1:0];
        REG_TILT_MIN:   tilt_min_r   <= cfg_data[POS_W-1:0];
        REG_TILT_MAX:   tilt_max_r   <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic signed [POS_W-1:0] pan_pos_r, pan_pos_nxt;
  logic signed [POS_W-1:0] tilt_pos_r, tilt_pos_nxt;
  logic                    sweep_right_r, sweep_right_nxt;
  logic                    sweep_down_r, sweep_down_nxt;
  logic                    is_asleep_r, is_asleep_nxt;
  logic                    is_roaming_r, is_roaming_nxt;
  logic [TIMER_BITS-1:0]   sleep_timer_r, sleep_timer_nxt;

  logic                    in_accept;
  logic                    res_valid;
  out_item_t               res_data;

  logic signed [SUM_W-1:0] step_s;
  logic signed [SUM_W-1:0] track_pan_sum;
  logic signed [SUM_W-1:0] track_tilt_sum;
  logic signed [SUM_W-1:0] roam_pan_sum;
  logic signed [SUM_W-1:0] roam_tilt_sum;
  logic signed [POS_W-1:0] roam_pan;
  logic signed [POS_W-1:0] roam_tilt;
  logic                    timer_over;
  logic                    roam_now;

  assign in_accept = in_valid && !in_stall;

  assign step_s         = $signed({{(SUM_W-STEP_W){1'b0}}, sweep_step_r});
  assign track_pan_sum  = SUM_W'(AIM_HOME)
                        + $signed({{(SUM_W-PIX_W){1'b0}}, in_data.face_x})
                        - $signed({{(SUM_W-CTR_W){1'b0}}, center_x_r});
  assign track_tilt_sum = SUM_W'(AIM_HOME)
                        + $signed({{(SUM_W-PIX_W){1'b0}}, in_data.face_y})
                        - $signed({{(SUM_W-CTR_W){1'b0}}, center_y_r});
  assign roam_pan_sum   = sweep_right_r ? SUM_W'(pan_pos_r) - step_s
                                        : SUM_W'(pan_pos_r) + step_s;
  assign roam_tilt_sum  = sweep_down_r  ? SUM_W'(tilt_pos_r) + step_s
                                        : SUM_W'(tilt_pos_r) - step_s;
  assign roam_pan       = sat12(roam_pan_sum);
  assign roam_tilt      = sat12(roam_tilt_sum);
  assign timer_over     = CMP_W'(sleep_timer_r) > CMP_W'(rest_ticks_r);
  assign roam_now       = is_roaming_r || timer_over;

  always_comb begin
    pan_pos_nxt     = pan_pos_r;
    tilt_pos_nxt    = tilt_pos_r;
    sweep_right_nxt = sweep_right_r;
    sweep_down_nxt  = sweep_down_r;
    is_asleep_nxt   = is_asleep_r;
    is_roaming_nxt  = is_roaming_r;
    sleep_timer_nxt = sleep_timer_r;
    res_valid       = 1'b0;
    res_data.mode_out = MODE_HOLD;
    if (in_data.action == ACT_TICK) begin
      if (sleep_timer_r != TIMER_FULL) begin
        sleep_timer_nxt = sleep_timer_r + 1'b1;
      end
    end else begin
      res_valid = 1'b1;
      if (in_data.face_found) begin
        pan_pos_nxt       = sat12(track_pan_sum);
        tilt_pos_nxt      = sat12(track_tilt_sum);
        is_asleep_nxt     = 1'b0;
        is_roaming_nxt    = 1'b0;
        res_data.mode_out = MODE_TRACK;
      end else if (!is_asleep_r) begin
        is_asleep_nxt   = 1'b1;
        is_roaming_nxt  = 1'b0;
        sleep_timer_nxt = '0;
      end else if (roam_now) begin
        is_roaming_nxt    = 1'b1;
        pan_pos_nxt       = roam_pan;
        tilt_pos_nxt      = roam_tilt;
        res_data.mode_out = MODE_ROAM;
        if (roam_pan <= pan_min_r && sweep_right_r) begin
          sweep_right_nxt = 1'b0;
        end else if (roam_pan >= pan_max_r && !sweep_right_r) begin
          sweep_right_nxt = 1'b1;
        end
        if (roam_tilt <= tilt_min_r && !sweep_down_r) begin
          sweep_down_nxt = 1'b1;
        end else if (roam_tilt >= tilt_max_r && sweep_down_r) begin
          sweep_down_nxt = 1'b0;
        end
      end
    end
    res_data.pan_out  = pan_pos_nxt;
    res_data.tilt_out = tilt_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_pos_r     <= AIM_HOME;
      tilt_pos_r    <= AIM_HOME;
      sweep_right_r <= 1'b1;
      sweep_down_r  <= 1'b1;
      is_asleep_r   <= 1'b0;
      is_roaming_r  <= 1'b0;
      sleep_timer_r <= '0;
    end else if (in_accept) begin
      pan_pos_r     <= pan_pos_nxt;
      tilt_pos_r    <= tilt_pos_nxt;
      sweep_right_r <= sweep_right_nxt;
      sweep_down_r  <= sweep_down_nxt;
      is_asleep_r   <= is_asleep_nxt;
      is_roaming_r  <= is_roaming_nxt;
      sleep_timer_r <= sleep_timer_nxt;
    end
  end

  // result register with skid entry
  logic      out_valid_r;
  logic      skid_valid_r;
  out_item_t out_r;
  out_item_t skid_r;
  logic      out_free;
  logic      push;

  assign out_free = !out_valid_r || !out_stall;
  assign push     = in_accept && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res_data;
      end
    end else if (push) begin
      skid_r <= res_data;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/core/ptt_checker.sv
`default_nettype none

module ptt_checker
  import ptt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  logic in_take;
  assign in_take = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_out <= MODE_ROAM)
    else $error("undefined mode on result");

  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.action == ACT_TICK && !out_valid |=> !out_valid)
    else $error("tick item produced a result");

  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.action == ACT_FRAME && !out_valid |=> out_valid)
    else $error("frame item produced no result");

  a_track_mode: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.action == ACT_FRAME && in_data.face_found && !out_valid
    |=> out_data.mode_out == MODE_TRACK)
    else $error("found target not reported as tracking");

endmodule

bind pan_tilt_track_roam_fsm_core ptt_checker u_ptt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ptt_pkg::*;

  localparam int TMR_W  = 8;
  localparam int N_REGS = 8;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    in_item_t             item;
    logic                 typed;
    out_item_t            res;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] val;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // typed expectation travelling with the item being offered
  logic      row_typed;
  out_item_t row_res;

  pan_tilt_track_roam_fsm_core #(
    .TIMER_BITS(TMR_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // aim predictor state
  logic signed [POS_W-1:0] aim_pan;
  logic signed [POS_W-1:0] aim_tilt;
  logic                    pan_rev;
  logic                    tilt_fwd;
  logic                    dozing;
  logic                    roaming;
  logic [TMR_W-1:0]        idle_ticks;

  logic [REST_W-1:0]       c_rest;
  logic [CTR_W-1:0]        c_cx;
  logic [CTR_W-1:0]        c_cy;
  logic [STEP_W-1:0]       c_step;
  logic signed [POS_W-1:0] c_pmin;
  logic signed [POS_W-1:0] c_pmax;
  logic signed [POS_W-1:0] c_tmin;
  logic signed [POS_W-1:0] c_tmax;

  out_item_t aim_q[$];
  int        fails;
  int        items_sent;
  int        cur_set [N_REGS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function logic signed [POS_W-1:0] clamp12(int v);
    if (v > 2047) return 12'h7FF;
    if (v < -2048) return 12'h800;
    return v[POS_W-1:0];
  endfunction

  task aim_step(input in_item_t it, output bit got, output out_item_t res);
    logic [MODE_W-1:0] mode;
    int                s;
    got = 1'b0;
    res = '0;
    if (it.action == ACT_TICK) begin
      if (~&idle_ticks) idle_ticks = idle_ticks + 1'b1;
    end else begin
      if (it.face_found) begin
        aim_pan  = clamp12(int'(AIM_HOME) + int'(it.face_x) - int'(c_cx));
        aim_tilt = clamp12(int'(AIM_HOME) + int'(it.face_y) - int'(c_cy));
        dozing   = 1'b0;
        roaming  = 1'b0;
        mode     = MODE_TRACK;
      end else if (!dozing) begin
        dozing     = 1'b1;
        roaming    = 1'b0;
        idle_ticks = '0;
        mode       = MODE_HOLD;
      end else begin
        if (idle_ticks > c_rest) roaming = 1'b1;
        if (roaming) begin
          s = int'(c_step);
          aim_pan  = clamp12(pan_rev ? int'(aim_pan) - s : int'(aim_pan) + s);
          aim_tilt = clamp12(tilt_fwd ? int'(aim_tilt) + s : int'(aim_tilt) - s);
          if (aim_pan <= c_pmin && pan_rev) pan_rev = 1'b0;
          else if (aim_pan >= c_pmax && !pan_rev) pan_rev = 1'b1;
          if (aim_tilt <= c_tmin && !tilt_fwd) tilt_fwd = 1'b1;
          else if (aim_tilt >= c_tmax && tilt_fwd) tilt_fwd = 1'b0;
          mode = MODE_ROAM;
        end else begin
          mode = MODE_HOLD;
        end
      end
      got          = 1'b1;
      res.pan_out  = aim_pan;
      res.tilt_out = aim_tilt;
      res.mode_out = mode;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t pred;
    bit        got;
    if (!rst_n) begin
      aim_pan    = AIM_HOME;
      aim_tilt   = AIM_HOME;
      pan_rev    = 1'b1;
      tilt_fwd   = 1'b1;
      dozing     = 1'b0;
      roaming    = 1'b0;
      idle_ticks = '0;
      c_rest     = RST_REST_TICKS;
      c_cx       = RST_CENTER_X;
      c_cy       = RST_CENTER_Y;
      c_step     = RST_SWEEP_STEP;
      c_pmin     = RST_PAN_MIN;
      c_pmax     = RST_PAN_MAX;
      c_tmin     = RST_TILT_MIN;
      c_tmax     = RST_TILT_MAX;
      aim_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (aim_q.size() == 0) begin
          fails++;
          $display("%0t unexpected result: pan %0d tilt %0d mode %0d", $time,
                   out_data.pan_out, out_data.tilt_out, out_data.mode_out);
        end else begin
          want = aim_q.pop_front();
          if (out_data.pan_out !== want.pan_out) begin
            fails++;
            $display("%0t pan_out exp %0d got %0d", $time, want.pan_out, out_data.pan_out);
          end
          if (out_data.tilt_out !== want.tilt_out) begin
            fails++;
            $display("%0t tilt_out exp %0d got %0d", $time, want.tilt_out, out_data.tilt_out);
          end
          if (out_data.mode_out !== want.mode_out) begin
            fails++;
            $display("%0t mode_out exp %0d got %0d", $time, want.mode_out, out_data.mode_out);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REST_TICKS: c_rest = cfg_data[REST_W-1:0];
          REG_CENTER_X:   c_cx   = cfg_data[CTR_W-1:0];
          REG_CENTER_Y:   c_cy   = cfg_data[CTR_W-1:0];
          REG_SWEEP_STEP: c_step = cfg_data[STEP_W-1:0];
          REG_PAN_MIN:    c_pmin = cfg_data[POS_W-1:0];
          REG_PAN_MAX:    c_pmax = cfg_data[POS_W-1:0];
          REG_TILT_MIN:   c_tmin = cfg_data[POS_W-1:0];
          REG_TILT_MAX:   c_tmax = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        aim_step(in_data, got, pred);
        if (got) aim_q.insert(aim_q.size(), row_typed ? row_res : pred);
      end
    end
  end

  initial begin : out_side
    int left;
    int r;
    bit lvl;
    out_stall = 1'b0;
    left = 0;
    lvl = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          lvl = 1'b0;
          left = $urandom_range(1, 6);
        end else if (r < 80) begin
          lvl = 1'b1;
          left = $urandom_range(1, 3);
        end else if (r < 92) begin
          lvl = 1'b1;
          left = $urandom_range(4, 15);
        end else if (r < 96) begin
          lvl = 1'b1;
          left = $urandom_range(30, 80);
        end else begin
          lvl = 1'b0;
          left = $urandom_range(100, 300);
        end
      end
      out_stall = lvl;
      left--;
    end
  end

  function int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function in_item_t mk_item(logic act, logic fnd, int x, int y);
    in_item_t it;
    it.action     = act;
    it.face_found = fnd;
    it.face_x     = x[PIX_W-1:0];
    it.face_y     = y[PIX_W-1:0];
    return it;
  endfunction

  function in_item_t rnd_item(logic act, logic fnd);
    return mk_item(act, fnd, $urandom, $urandom);
  endfunction

  function int pick_px(int ctr);
    int v;
    if ($urandom_range(0, 1)) return $urandom_range(0, 4095);
    v = ctr + int'($urandom_range(0, 400)) - 200;
    if (v < 0) v = 0;
    return v;
  endfunction

  function row_t frm(logic fnd, int x, int y, logic typed, int pan, int tilt,
                     logic [MODE_W-1:0] mode);
    row_t r;
    r = '0;
    r.kind         = ROW_ITEM;
    r.item         = mk_item(ACT_FRAME, fnd, x, y);
    r.typed        = typed;
    r.res.pan_out  = pan[POS_W-1:0];
    r.res.tilt_out = tilt[POS_W-1:0];
    r.res.mode_out = mode;
    return r;
  endfunction

  function row_t tck(logic fnd, int x, int y);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = mk_item(ACT_TICK, fnd, x, y);
    return r;
  endfunction

  function row_t wr(logic [CFG_IDX_W-1:0] idx, int val);
    row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val[CFG_DAT_W-1:0];
    return r;
  endfunction

  function logic [CFG_DAT_W-1:0] reg_mask(logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_REST_TICKS:             return CFG_DAT_W'((1 << REST_W) - 1);
      REG_CENTER_X, REG_CENTER_Y: return CFG_DAT_W'((1 << CTR_W) - 1);
      REG_SWEEP_STEP:             return CFG_DAT_W'((1 << STEP_W) - 1);
      default:                    return CFG_DAT_W'((1 << POS_W) - 1);
    endcase
  endfunction

  task settle();
    while (aim_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task send(input in_item_t it, input logic typed, input out_item_t res, input bit calm);
    int g;
    g = calm ? 0 : pause_len();
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_data   = it;
    row_typed = typed;
    row_res   = res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task choose(input int rest, cx, cy, step, pmin, pmax, tmin, tmax);
    cur_set[REG_REST_TICKS] = rest;
    cur_set[REG_CENTER_X]   = cx;
    cur_set[REG_CENTER_Y]   = cy;
    cur_set[REG_SWEEP_STEP] = step;
    cur_set[REG_PAN_MIN]    = pmin;
    cur_set[REG_PAN_MAX]    = pmax;
    cur_set[REG_TILT_MIN]   = tmin;
    cur_set[REG_TILT_MAX]   = tmax;
  endtask

  task program_regs();
    logic [CFG_IDX_W-1:0] ri;
    logic [CFG_DAT_W-1:0] mk;
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    settle();
    for (int i = 0; i < N_REGS; i++) begin
      ri = CFG_IDX_W'(i);
      mk = reg_mask(ri);
      write_reg(ri, (CFG_DAT_W'(cur_set[i]) & mk) | (CFG_DAT_W'($urandom) & ~mk));
    end
    cfg_valid = 1'b0;
  endtask

  // lost frame, enough ticks to pin the timer at full scale, then lost frames
  task fill_timer(input bit calm);
    out_item_t none;
    none = '0;
    send(rnd_item(ACT_FRAME, 1'b0), 1'b0, none, calm);
    repeat (256 + $urandom_range(0, 8))
      send(rnd_item(ACT_TICK, 1'($urandom)), 1'b0, none, calm);
    repeat (2) send(rnd_item(ACT_FRAME, 1'b0), 1'b0, none, calm);
  endtask

  task run_phase(input int quota, input bit force_full);
    int        stop;
    int        k;
    int        r;
    int        rest;
    bit        calm;
    in_item_t  junk;
    out_item_t none;
    none = '0;
    rest = cur_set[REG_REST_TICKS];
    stop = items_sent + quota;
    if (force_full) fill_timer(1'b0);
    while (items_sent < stop) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      if (r < 3) begin
        repeat ($urandom_range(1, 4)) begin
          junk = mk_item(1'($urandom), 1'($urandom), $urandom, $urandom);
          send(junk, 1'b0, none, calm);
        end
      end else if (r < 7) begin
        repeat ($urandom_range(1, 6))
          send(mk_item(ACT_FRAME, 1'b1, pick_px(cur_set[REG_CENTER_X]),
                       pick_px(cur_set[REG_CENTER_Y])), 1'b0, none, calm);
      end else if (r < 18) begin
        send(rnd_item(ACT_FRAME, 1'b0), 1'b0, none, calm);
        if (rest < 250)
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rest)
                                          : rest + 1 + $urandom_range(0, 3);
        else
          k = $urandom_range(0, 12);
        repeat (k) send(rnd_item(ACT_TICK, 1'($urandom)), 1'b0, none, calm);
        repeat ($urandom_range(1, 40)) begin
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
              send(rnd_item(ACT_TICK, 1'($urandom)), 1'b0, none, calm);
          send(rnd_item(ACT_FRAME, 1'b0), 1'b0, none, calm);
        end
      end else begin
        in_valid = 1'b0;
        settle();
      end
    end
  endtask

  initial begin : main
    row_t rows[$];
    int   pmin;
    int   tmin;
    int   step;
    int   rest;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    row_typed  = 1'b0;
    row_res    = '0;
    rst_n      = 1'b0;
    fails      = 0;
    items_sent = 0;

    rows.insert(rows.size(), frm(1'b1, 320, 240, 1'b1, 90, 90, MODE_TRACK));
    rows.insert(rows.size(), frm(1'b1, 4095, 4095, 1'b1, 2047, 2047, MODE_TRACK));
    rows.insert(rows.size(), frm(1'b1, 0, 0, 1'b1, -230, -150, MODE_TRACK));
    rows.insert(rows.size(), frm(1'b0, 4095, 4095, 1'b1, -230, -150, MODE_HOLD));
    rows.insert(rows.size(), tck(1'b1, 4095, 4095));
    rows.insert(rows.size(), frm(1'b0, 0, 0, 1'b1, -230, -150, MODE_HOLD));
    rows.insert(rows.size(), wr(REG_CENTER_X, 2047));
    rows.insert(rows.size(), wr(REG_CENTER_Y, 2047));
    rows.insert(rows.size(), frm(1'b1, 0, 0, 1'b1, -1957, -1957, MODE_TRACK));
    rows.insert(rows.size(), wr(REG_REST_TICKS, 0));
    rows.insert(rows.size(), wr(REG_SWEEP_STEP, 255));
    rows.insert(rows.size(), wr(REG_PAN_MIN, -2048));
    rows.insert(rows.size(), frm(1'b0, 0, 0, 1'b1, -1957, -1957, MODE_HOLD));
    rows.insert(rows.size(), tck(1'b0, 0, 0));
    rows.insert(rows.size(), frm(1'b0, 2730, 1365, 1'b0, 0, 0, MODE_TRACK));
    rows.insert(rows.size(), frm(1'b0, 1365, 2730, 1'b0, 0, 0, MODE_TRACK));
    rows.insert(rows.size(), wr(REG_SWEEP_STEP, 0));
    rows.insert(rows.size(), frm(1'b0, 0, 0, 1'b0, 0, 0, MODE_TRACK));
    rows.insert(rows.size(), frm(1'b1, 4095, 0, 1'b1, 2047, -1957, MODE_TRACK));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        in_valid  = 1'b0;
        cfg_valid = 1'b0;
        settle();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        cfg_valid = 1'b0;
        send(rows[i].item, rows[i].typed, rows[i].res, 1'b0);
      end
    end

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: choose(5000, 320, 240, 1, 0, 180, 75, 125);
        1: choose(3, 320, 240, 5, 0, 180, 75, 125);
        2: choose(0, 2047, 2047, 255, -2048, 2047, -2048, 2047);
        3: choose(0, 0, 0, 0, 2047, -2048, 2047, -2048);
        4: choose(16777215, 0, 2047, 1, -100, 100, -50, 50);
        default: begin
          rest = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 40);
          step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
          pmin = int'($urandom_range(0, 400)) - 200;
          tmin = int'($urandom_range(0, 400)) - 200;
          choose(rest, $urandom_range(0, 2047), $urandom_range(0, 2047), step, pmin,
                 ($urandom_range(0, 3) == 0) ? pmin - int'($urandom_range(0, 50))
                                             : pmin + int'($urandom_range(0, 200)),
                 tmin,
                 ($urandom_range(0, 3) == 0) ? tmin - int'($urandom_range(0, 50))
                                             : tmin + int'($urandom_range(0, 200)));
        end
      endcase
      program_regs();
      run_phase(72, ph == 1 || ph == 5);
    end

    in_valid = 1'b0;
    while (aim_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ptt_pkg.sv
rtl/core/pan_tilt_track_roam_fsm_core.sv
rtl/core/ptt_checker.sv
tb/testbench.sv
